>>> src/pscc_pkg.sv
`default_nettype none

package pscc_pkg;

   localparam int HORIZON_DEFAULT     = 65536;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CMD_W       = 2;
   localparam int TIME_W      = 17;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 8;
   localparam int CMD_LSB     = 0;
   localparam int START_LSB   = 2;
   localparam int END_LSB     = 19;
   localparam int PERIOD_LSB  = 36;

   localparam int WORD_W   = 64;
   localparam int WORD_LOG = 6;
   localparam int KIND_W   = 2;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ONCE   = 2'd1,
      CMD_REPEAT = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_CLEAR,
      KIND_ONCE,
      KIND_REPEAT
   } kind_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } back_state_type;

   // slot register width, never narrower than one word index plus a bit offset
   function automatic int slot_width(input int horizon);
      int w;
      w = $clog2(horizon + 1);
      if (w < WORD_LOG + 1) begin
         w = WORD_LOG + 1;
      end
      return w;
   endfunction

   function automatic int map_words(input int horizon);
      return (horizon >> WORD_LOG) + 1;
   endfunction

   function automatic int addr_width(input int words);
      return (words > 1) ? $clog2(words) : 1;
   endfunction

   // queue entry: kind, first slot, last slot, period, last flag
   function automatic int entry_width(input int horizon);
      return KIND_W + 3 * slot_width(horizon) + 1;
   endfunction

endpackage

`default_nettype wire

>>> src/pscc_ram.sv
`default_nettype none

module pscc_ram #(
   parameter int WIDTH = pscc_pkg::WORD_W,
   parameter int DEPTH = pscc_pkg::map_words(pscc_pkg::HORIZON_DEFAULT)
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [pscc_pkg::addr_width(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [pscc_pkg::addr_width(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/pscc_queue.sv
`default_nettype none

module pscc_queue #(
   parameter int DATA_W = pscc_pkg::entry_width(pscc_pkg::HORIZON_DEFAULT),
   parameter int DEPTH  = pscc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] wdata,
   output logic                   full,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      rdata,
   output logic                   not_empty
);

   localparam int PTR_W = pscc_pkg::addr_width(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rdata     = mem_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

endmodule

`default_nettype wire

>>> src/pscc_front.sv
`default_nettype none

module pscc_front #(
   parameter int HORIZON = pscc_pkg::HORIZON_DEFAULT
) (
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   input  wire logic [pscc_pkg::REQ_TDATA_W-1:0]          req_tdata,
   input  wire logic                                      req_tlast,
   input  wire logic                                      init_busy,
   input  wire logic                                      q_full,
   output logic                                           q_push,
   output logic [pscc_pkg::entry_width(HORIZON)-1:0]      q_wdata
);

   localparam int SW    = pscc_pkg::slot_width(HORIZON);
   localparam int CMP_W = (SW > pscc_pkg::TIME_W) ? SW : pscc_pkg::TIME_W;
   localparam logic [CMP_W-1:0] H_C = CMP_W'(HORIZON);

   pscc_pkg::cmd_type  cmd;
   pscc_pkg::kind_type kind;
   logic [CMP_W-1:0]   start_x, end_x, period_x;
   logic [CMP_W-1:0]   end_clip, period_clip;
   logic               nonempty;
   logic [SW-1:0]      lo_slot, hi_slot, per_slot;

   assign cmd      = pscc_pkg::cmd_type'(req_tdata[pscc_pkg::CMD_LSB +: pscc_pkg::CMD_W]);
   assign start_x  = CMP_W'(req_tdata[pscc_pkg::START_LSB +: pscc_pkg::TIME_W]);
   assign end_x    = CMP_W'(req_tdata[pscc_pkg::END_LSB +: pscc_pkg::TIME_W]);
   assign period_x = CMP_W'(req_tdata[pscc_pkg::PERIOD_LSB +: pscc_pkg::TIME_W]);

   // end saturates at the horizon; a longer period behaves as the horizon itself
   assign end_clip    = (end_x > H_C) ? H_C : end_x;
   assign period_clip = (period_x > H_C) ? H_C : period_x;
   assign nonempty    = (end_clip > start_x);

   assign lo_slot  = SW'(start_x + CMP_W'(1));
   assign hi_slot  = SW'(end_clip);
   assign per_slot = SW'(period_clip);

   always_comb begin
      unique case (cmd)
         pscc_pkg::CMD_CLEAR:  kind = pscc_pkg::KIND_CLEAR;
         pscc_pkg::CMD_ONCE:   kind = nonempty ? pscc_pkg::KIND_ONCE : pscc_pkg::KIND_NOP;
         pscc_pkg::CMD_REPEAT: kind = nonempty ? pscc_pkg::KIND_REPEAT : pscc_pkg::KIND_NOP;
         pscc_pkg::CMD_UNUSED: kind = pscc_pkg::KIND_NOP;
         default:              kind = pscc_pkg::KIND_NOP;
      endcase
   end

   assign req_tready = !q_full && !init_busy;
   assign q_push     = req_tvalid && req_tready;
   assign q_wdata    = {kind, lo_slot, hi_slot, per_slot, req_tlast};

endmodule

`default_nettype wire

>>> src/pscc_back.sv
`default_nettype none

module pscc_back #(
   parameter int HORIZON = pscc_pkg::HORIZON_DEFAULT
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      q_valid,
   input  wire logic [pscc_pkg::entry_width(HORIZON)-1:0] q_rdata,
   output logic                                           q_pop,
   output logic                                           init_busy,
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   output logic [pscc_pkg::RSP_TDATA_W-1:0]               rsp_tdata,
   output logic                                           rsp_tlast
);

   localparam int SW        = pscc_pkg::slot_width(HORIZON);
   localparam int MAP_WORDS = pscc_pkg::map_words(HORIZON);
   localparam int ADDR_W    = pscc_pkg::addr_width(MAP_WORDS);
   localparam int WORD_W    = pscc_pkg::WORD_W;
   localparam int WORD_LOG  = pscc_pkg::WORD_LOG;
   localparam int KIND_W    = pscc_pkg::KIND_W;
   localparam logic [SW:0]       H_X       = (SW + 1)'(HORIZON);
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

   pscc_pkg::back_state_type state_ff, state_in;

   pscc_pkg::kind_type q_kind;
   logic [SW-1:0]      q_lo, q_hi, q_per;
   logic               q_last;

   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              sweep_rsp_ff, sweep_rsp_in;
   logic              conflict_ff, conflict_in;
   logic [SW-1:0]     lo_ff, lo_in;
   logic [SW-1:0]     hi_ff, hi_in;
   logic [SW-1:0]     per_ff, per_in;
   logic              repeat_ff, repeat_in;
   logic              last_ff, last_in;
   logic              zero_pend_ff, zero_pend_in;
   logic [ADDR_W-1:0] word_ff, word_in;

   logic              b_valid_ff, b_valid_in;
   logic [ADDR_W-1:0] b_addr_ff;
   logic [WORD_W-1:0] b_mask_ff, b_mask_in;

   logic              fw_valid_ff;
   logic [ADDR_W-1:0] fw_addr_ff;
   logic [WORD_W-1:0] fw_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_conflict_ff, rsp_conflict_in;
   logic              rsp_last_ff, rsp_last_in;

   logic                sweeping, issue, done, done_flag, done_last, out_free;
   logic [ADDR_W-1:0]   lo_word, hi_word;
   logic [WORD_LOG-1:0] lo_bit, hi_bit;
   logic [SW:0]         lo_next, hi_sum, hi_next;
   logic                more_windows;
   logic [WORD_W-1:0]   rd_data, cur_data, merged;
   logic                hit, b_write;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [WORD_W-1:0]   ram_wr_data;

   assign q_last = q_rdata[0];
   assign q_per  = q_rdata[SW:1];
   assign q_hi   = q_rdata[2*SW:SW+1];
   assign q_lo   = q_rdata[3*SW:2*SW+1];
   assign q_kind = pscc_pkg::kind_type'(q_rdata[3*SW+KIND_W:3*SW+1]);

   // mask of the slots of the current window within the current word
   assign lo_word = ADDR_W'(lo_ff >> WORD_LOG);
   assign hi_word = ADDR_W'(hi_ff >> WORD_LOG);
   assign lo_bit  = (word_ff == lo_word) ? lo_ff[WORD_LOG-1:0] : '0;
   assign hi_bit  = (word_ff == hi_word) ? hi_ff[WORD_LOG-1:0] : '1;
   assign b_mask_in = ({WORD_W{1'b1}} << lo_bit)
                    & ({WORD_W{1'b1}} >> (WORD_LOG'(WORD_W - 1) - hi_bit));

   // next window of a repeating task
   assign lo_next      = {1'b0, lo_ff} + {1'b0, per_ff};
   assign hi_sum       = {1'b0, hi_ff} + {1'b0, per_ff};
   assign hi_next      = (hi_sum > H_X) ? H_X : hi_sum;
   assign more_windows = repeat_ff && (per_ff != '0) && (lo_next <= H_X);

   // check and merge, with the word written last cycle forwarded
   assign cur_data = (fw_valid_ff && (fw_addr_ff == b_addr_ff)) ? fw_data_ff : rd_data;
   assign hit      = b_valid_ff && ((cur_data & b_mask_ff) != '0);
   assign b_write  = b_valid_ff && !hit;
   assign merged   = cur_data | b_mask_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      conflict_in  = conflict_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      per_in       = per_ff;
      repeat_in    = repeat_ff;
      last_in      = last_ff;
      zero_pend_in = zero_pend_ff;
      word_in      = word_ff;
      sweeping     = 1'b0;
      issue        = 1'b0;
      q_pop        = 1'b0;
      done         = 1'b0;
      done_flag    = conflict_ff;
      done_last    = last_ff;
      unique case (state_ff)
         pscc_pkg::ST_SWEEP: begin
            sweeping = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_WORD) begin
               state_in    = pscc_pkg::ST_IDLE;
               conflict_in = 1'b0;
               if (sweep_rsp_ff) begin
                  done      = 1'b1;
                  done_flag = 1'b0;
               end
            end
         end
         pscc_pkg::ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop     = 1'b1;
               last_in   = q_last;
               done_last = q_last;
               unique case (q_kind)
                  pscc_pkg::KIND_CLEAR: begin
                     state_in     = pscc_pkg::ST_SWEEP;
                     sweep_in     = '0;
                     sweep_rsp_in = 1'b1;
                  end
                  pscc_pkg::KIND_ONCE, pscc_pkg::KIND_REPEAT: begin
                     if (conflict_ff) begin
                        done = 1'b1;
                     end else begin
                        state_in  = pscc_pkg::ST_WALK;
                        lo_in     = q_lo;
                        hi_in     = q_hi;
                        per_in    = q_per;
                        repeat_in = (q_kind == pscc_pkg::KIND_REPEAT);
                        word_in   = ADDR_W'(q_lo >> WORD_LOG);
                     end
                  end
                  pscc_pkg::KIND_NOP: begin
                     done = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         pscc_pkg::ST_WALK: begin
            issue = 1'b1;
            if (hit) begin
               conflict_in = 1'b1;
               done        = 1'b1;
               done_flag   = 1'b1;
               state_in    = pscc_pkg::ST_IDLE;
            end else if (word_ff == hi_word) begin
               if (more_windows) begin
                  lo_in   = lo_next[SW-1:0];
                  hi_in   = hi_next[SW-1:0];
                  word_in = ADDR_W'(lo_next >> WORD_LOG);
               end else begin
                  state_in     = pscc_pkg::ST_FLUSH;
                  zero_pend_in = repeat_ff && (per_ff == '0);
               end
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         pscc_pkg::ST_FLUSH: begin
            // a repeating task with zero period would claim its window again
            done_flag   = conflict_ff || hit || zero_pend_ff;
            conflict_in = done_flag;
            done        = 1'b1;
            state_in    = pscc_pkg::ST_IDLE;
         end
         default: begin
            state_in = pscc_pkg::ST_IDLE;
         end
      endcase
   end

   assign b_valid_in = issue && !hit;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_conflict_in = rsp_conflict_ff;
      rsp_last_in     = rsp_last_ff;
      if (done) begin
         rsp_valid_in    = 1'b1;
         rsp_conflict_in = done_flag;
         rsp_last_in     = done_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pscc_pkg::ST_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         conflict_ff  <= 1'b0;
         b_valid_ff   <= 1'b0;
         fw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         conflict_ff  <= conflict_in;
         b_valid_ff   <= b_valid_in;
         fw_valid_ff  <= b_write;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      per_ff          <= per_in;
      repeat_ff       <= repeat_in;
      last_ff         <= last_in;
      zero_pend_ff    <= zero_pend_in;
      word_ff         <= word_in;
      b_addr_ff       <= word_ff;
      b_mask_ff       <= b_mask_in;
      fw_addr_ff      <= b_addr_ff;
      fw_data_ff      <= merged;
      rsp_conflict_ff <= rsp_conflict_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign ram_wr_en   = sweeping || b_write;
   assign ram_wr_addr = sweeping ? sweep_ff : b_addr_ff;
   assign ram_wr_data = sweeping ? '0 : merged;

   pscc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (word_ff),
      .rd_data (rd_data)
   );

   assign init_busy  = (state_ff == pscc_pkg::ST_SWEEP) && !sweep_rsp_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pscc_pkg::RSP_TDATA_W - 1){1'b0}}, rsp_conflict_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_flush_has_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pscc_pkg::ST_FLUSH) |-> b_valid_ff)
      else $error("flush without a word in the check stage");

   a_sweep_alone: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pscc_pkg::ST_SWEEP) |-> !b_valid_ff)
      else $error("map update during a clearing pass");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      (done && rsp_valid_ff) |-> rsp_tready)
      else $error("result overwrites one not yet taken");

endmodule

`default_nettype wire

>>> src/periodic_slot_conflict_checker.sv
`default_nettype none

// channel  | dir | tdata (lsb first)                               | tlast
// req      | in  | cmd[2] start_time[17] end_time[17] period[17]   | last_task
// rsp      | out | conflict[1]                                     | set_done
//
// after reset every map word is zeroed before req_tready rises
// a clear item zeroes every map word in the back end and answers with no conflict
// a task walks each map word that its windows touch, window by window, and stops at a hit
// the map port (one read-modify-write per cycle) sets the task time
// a short queue parts intake from the map walk; rsp holds in its output register

module periodic_slot_conflict_checker #(
   parameter int HORIZON     = pscc_pkg::HORIZON_DEFAULT,
   parameter int QUEUE_DEPTH = pscc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // cmd, start_time, end_time, period, zero fill
   input  wire logic [pscc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                             req_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // conflict, zero fill
   output logic [pscc_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int ENTRY_W = pscc_pkg::entry_width(HORIZON);

   logic               init_busy;
   logic               q_full, q_push, q_pop, q_valid;
   logic [ENTRY_W-1:0] q_wdata, q_rdata;

   pscc_front #(
      .HORIZON (HORIZON)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .init_busy  (init_busy),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   pscc_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .rdata     (q_rdata),
      .not_empty (q_valid)
   );

   pscc_back #(
      .HORIZON (HORIZON)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .init_busy  (init_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
